// ----- sv/pgra_pkg.sv -----
// Shared types and constants for the PID gain round adjuster.
// No dependencies; used by every module of the block by scoped names.
package pgra_pkg;

	// Default gain width (Q8.16); top-level parameter default
	localparam int GAIN_WIDTH_DEF = 24;

	// Fixed field widths
	localparam int ERR_W   = 24;   // Q16.8 error fields
	localparam int ROUND_W = 7;
	localparam int OUT_W   = 24;   // result gain fields
	localparam int K_W     = 17;   // Q1.16 scale factors
	localparam int RATIO_W = 16;   // Q0.16 change ratios
	localparam int CEIL_W  = 24;
	localparam int CFG_W   = 24;   // widest register
	localparam int IDX_W   = 3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_CONS_ENABLE = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_FACTOR = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_P_CHG   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_I_CHG   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_D_CHG   = 3'd4;
	localparam logic [IDX_W-1:0] REG_P_CEIL      = 3'd5;
	localparam logic [IDX_W-1:0] REG_I_CEIL      = 3'd6;
	localparam logic [IDX_W-1:0] REG_D_CEIL      = 3'd7;

	// Register reset values
	localparam logic                RST_CONS_ENABLE = 1'b1;
	localparam logic [K_W-1:0]      RST_GAIN_FACTOR = 17'd32768;
	localparam logic [RATIO_W-1:0]  RST_MAX_CHG     = 16'd13107;
	localparam logic [CEIL_W-1:0]   RST_P_CEIL      = 24'd6553600;
	localparam logic [CEIL_W-1:0]   RST_I_CEIL      = 24'd655360;
	localparam logic [CEIL_W-1:0]   RST_D_CEIL      = 24'd655360;

	// Rule scale factors, Q1.16 nearest
	localparam logic [K_W-1:0] K_ZERO = 17'd0;
	localparam logic [K_W-1:0] K_0P9  = 17'd58982;
	localparam logic [K_W-1:0] K_ONE  = 17'd65536;
	localparam logic [K_W-1:0] K_1P2  = 17'd78643;
	localparam logic [K_W-1:0] K_1P3  = 17'd85197;

	// Error thresholds, Q16.8
	localparam logic [ERR_W-1:0] ERR_50 = 24'd12800;
	localparam logic [ERR_W-1:0] ERR_10 = 24'd2560;
	localparam logic [ERR_W-1:0] ERR_2  = 24'd512;
	localparam logic [ERR_W-1:0] ERR_1  = 24'd256;

	// Last round that still counts as early
	localparam logic [ROUND_W-1:0] EARLY_ROUND_MAX = 7'd2;

	typedef enum logic [2:0] {
		RULE_CONSERVATIVE = 3'd0,
		RULE_OSCILLATION  = 3'd1,
		RULE_SLOW         = 3'd2,
		RULE_STEADY_STATE = 3'd3,
		RULE_HOLD         = 3'd4
	} rule_t;

	typedef struct packed {
		logic                cons_enable;
		logic [K_W-1:0]      gain_factor;
		logic [RATIO_W-1:0]  p_rate_lim;
		logic [RATIO_W-1:0]  i_rate_lim;
		logic [RATIO_W-1:0]  d_rate_lim;
		logic [CEIL_W-1:0]   p_ceiling;
		logic [CEIL_W-1:0]   i_ceiling;
		logic [CEIL_W-1:0]   d_ceiling;
	} cfg_t;

	// Chosen rule and per-gain candidate scale (candidate = cur * k >> 16)
	typedef struct packed {
		rule_t           rule;
		logic [K_W-1:0]  kp;
		logic [K_W-1:0]  ki;
		logic [K_W-1:0]  kd;
	} rule_ctl_t;

endpackage

// ----- sv/pgra_cfg_regs.sv -----
// Configuration register file of the PID gain round adjuster.
// Depends on pgra_pkg (register indexes, reset values, cfg_t).
module pgra_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [pgra_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pgra_pkg::CFG_W-1:0]  cfg_data,
	output pgra_pkg::cfg_t              cfg
);

	pgra_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cons_enable <= pgra_pkg::RST_CONS_ENABLE;
			cfg_q.gain_factor <= pgra_pkg::RST_GAIN_FACTOR;
			cfg_q.p_rate_lim  <= pgra_pkg::RST_MAX_CHG;
			cfg_q.i_rate_lim  <= pgra_pkg::RST_MAX_CHG;
			cfg_q.d_rate_lim  <= pgra_pkg::RST_MAX_CHG;
			cfg_q.p_ceiling   <= pgra_pkg::RST_P_CEIL;
			cfg_q.i_ceiling   <= pgra_pkg::RST_I_CEIL;
			cfg_q.d_ceiling   <= pgra_pkg::RST_D_CEIL;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pgra_pkg::REG_CONS_ENABLE: cfg_q.cons_enable <= cfg_data[0];
				pgra_pkg::REG_GAIN_FACTOR: cfg_q.gain_factor <= cfg_data[pgra_pkg::K_W-1:0];
				pgra_pkg::REG_MAX_P_CHG:   cfg_q.p_rate_lim  <= cfg_data[pgra_pkg::RATIO_W-1:0];
				pgra_pkg::REG_MAX_I_CHG:   cfg_q.i_rate_lim  <= cfg_data[pgra_pkg::RATIO_W-1:0];
				pgra_pkg::REG_MAX_D_CHG:   cfg_q.d_rate_lim  <= cfg_data[pgra_pkg::RATIO_W-1:0];
				pgra_pkg::REG_P_CEIL:      cfg_q.p_ceiling   <= cfg_data[pgra_pkg::CEIL_W-1:0];
				pgra_pkg::REG_I_CEIL:      cfg_q.i_ceiling   <= cfg_data[pgra_pkg::CEIL_W-1:0];
				pgra_pkg::REG_D_CEIL:      cfg_q.d_ceiling   <= cfg_data[pgra_pkg::CEIL_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/pgra_rule_sel.sv -----
// Tuning rule decision: picks the rule and a Q1.16 scale for each gain.
// Depends on pgra_pkg (thresholds, factors, rule_ctl_t).
module pgra_rule_sel (
	input  logic                          cons_enable,
	input  logic [pgra_pkg::K_W-1:0]      gain_factor,
	input  logic [pgra_pkg::ERR_W-1:0]    err_mean,
	input  logic [pgra_pkg::ERR_W-1:0]    error_spread,
	input  logic [pgra_pkg::ROUND_W-1:0]  round_cnt,
	output pgra_pkg::rule_ctl_t           ctl
);

	// Hold uses a scale of exactly 1.0 so the candidate equals the current gain
	always_comb begin
		ctl.rule = pgra_pkg::RULE_HOLD;
		ctl.kp   = pgra_pkg::K_ONE;
		ctl.ki   = pgra_pkg::K_ONE;
		ctl.kd   = pgra_pkg::K_ONE;
		priority if (cons_enable && (round_cnt <= pgra_pkg::EARLY_ROUND_MAX)
				&& (err_mean > pgra_pkg::ERR_50)) begin
			ctl.rule = pgra_pkg::RULE_CONSERVATIVE;
			ctl.kp   = gain_factor;
			ctl.ki   = gain_factor;
			ctl.kd   = pgra_pkg::K_ZERO;
		end else if (error_spread > pgra_pkg::ERR_1) begin
			ctl.rule = pgra_pkg::RULE_OSCILLATION;
			ctl.kp   = pgra_pkg::K_0P9;
			ctl.kd   = pgra_pkg::K_1P2;
		end else if (err_mean > pgra_pkg::ERR_10) begin
			ctl.rule = pgra_pkg::RULE_SLOW;
			ctl.kp   = pgra_pkg::K_1P2;
		end else if (err_mean > pgra_pkg::ERR_2) begin
			ctl.rule = pgra_pkg::RULE_STEADY_STATE;
			ctl.ki   = pgra_pkg::K_1P3;
		end else begin
			ctl.rule = pgra_pkg::RULE_HOLD;
		end
	end

endmodule

// ----- sv/pgra_gain_limit.sv -----
// One gain lane: candidate scaling, relative rate limit and ceiling clamp.
// Depends on pgra_pkg (widths, K_ONE).
module pgra_gain_limit #(
	parameter int GW = pgra_pkg::GAIN_WIDTH_DEF
) (
	input  logic [GW-1:0]                  cur,
	input  logic [pgra_pkg::K_W-1:0]       k,
	input  logic [pgra_pkg::RATIO_W-1:0]   ratio,
	input  logic [pgra_pkg::CEIL_W-1:0]    ceiling,
	output logic [GW-1:0]                  res
);

	localparam int PW = GW + pgra_pkg::K_W;   // product width
	localparam int FB = 16;                   // fraction bits of Q16 factors

	logic [PW-1:0]                cand_prod;
	logic [PW-1:0]                cand_shift;
	logic [PW-1:0]                up_prod;
	logic [PW-1:0]                dn_prod;
	logic [pgra_pkg::K_W-1:0]     up_k;
	logic [pgra_pkg::K_W-1:0]     dn_k;
	logic [GW:0]                  cand;
	logic [GW:0]                  up_val;
	logic [GW:0]                  dn_val;
	logic [GW:0]                  one_val;
	logic [GW:0]                  lim;
	logic [GW+pgra_pkg::CEIL_W-1:0] ceil_ext;
	logic [GW-1:0]                ceil_m;

	assign up_k = pgra_pkg::K_ONE + pgra_pkg::K_W'(ratio);
	assign dn_k = pgra_pkg::K_ONE - pgra_pkg::K_W'(ratio);

	// Three independent multipliers, no chaining
	assign cand_prod = PW'(cur) * PW'(k);
	assign up_prod   = PW'(cur) * PW'(up_k);
	assign dn_prod   = PW'(cur) * PW'(dn_k);

	assign cand    = cand_prod[PW-1:FB];
	assign up_val  = up_prod[PW-1:FB];
	assign dn_val  = dn_prod[PW-1:FB];
	assign one_val = (GW+1)'(pgra_pkg::K_ONE);

	// Truncated candidate shifted back up, for the cross-multiplied ratio test
	assign cand_shift = {cand, {FB{1'b0}}};

	always_comb begin
		priority if (cur == '0) begin
			lim = (cand < one_val) ? cand : one_val;
		end else if (cand == '0) begin
			lim = dn_val;
		end else if (cand_shift > up_prod) begin
			lim = up_val;
		end else if (cand_shift < dn_prod) begin
			lim = dn_val;
		end else begin
			lim = cand;
		end
	end

	// Ceiling masked to the gain width (zero-extended when wider)
	assign ceil_ext = {{GW{1'b0}}, ceiling};
	assign ceil_m   = ceil_ext[GW-1:0];

	assign res = (lim < {1'b0, ceil_m}) ? lim[GW-1:0] : ceil_m;

endmodule

// ----- sv/pid_gain_round_adjuster.sv -----
// Top level of the PID gain round adjuster: handshake, pipeline registers,
// rule choice and three gain lanes. Depends on pgra_pkg, pgra_cfg_regs,
// pgra_rule_sel and pgra_gain_limit.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid / in_stall     | cur_p cur_i cur_d err_mean
//          |           |                         | error_spread round_cnt
//  out     | output    | out_valid / out_stall   | new_p new_i new_d rule_taken
//  cfg     | input     | cfg_wr_en (no wait)     | cfg_index cfg_data
//
//  One transaction per cycle sustained while out_stall is low. An input
//  transaction lands in the _s1 input register; the rule choice and the
//  three gain lanes (one multiplier depth each) run combinationally into
//  the _s2 result register, so out_valid rises once the item has moved
//  into _s2, and the result is taken at an edge with out_stall low.
//  arst_n clears both valid bits and loads the register reset values.
//  A held out_stall freezes _s2; _s1 still takes one more transaction,
//  then in_stall rises until the result register drains.
module pid_gain_round_adjuster #(
	parameter int GAIN_WIDTH = pgra_pkg::GAIN_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [GAIN_WIDTH-1:0]         cur_p,
	input  logic [GAIN_WIDTH-1:0]         cur_i,
	input  logic [GAIN_WIDTH-1:0]         cur_d,
	input  logic [pgra_pkg::ERR_W-1:0]    err_mean,
	input  logic [pgra_pkg::ERR_W-1:0]    error_spread,
	input  logic [pgra_pkg::ROUND_W-1:0]  round_cnt,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pgra_pkg::OUT_W-1:0]    new_p,
	output logic [pgra_pkg::OUT_W-1:0]    new_i,
	output logic [pgra_pkg::OUT_W-1:0]    new_d,
	output logic [2:0]                    rule_taken,

	input  logic                          cfg_wr_en,
	input  logic [pgra_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pgra_pkg::CFG_W-1:0]    cfg_data
);

	pgra_pkg::cfg_t       cfg;
	pgra_pkg::rule_ctl_t  ctl;

	// Stage 1: input register
	logic                          valid_s1;
	logic [GAIN_WIDTH-1:0]         cur_p_s1;
	logic [GAIN_WIDTH-1:0]         cur_i_s1;
	logic [GAIN_WIDTH-1:0]         cur_d_s1;
	logic [pgra_pkg::ERR_W-1:0]    err_mean_s1;
	logic [pgra_pkg::ERR_W-1:0]    error_spread_s1;
	logic [pgra_pkg::ROUND_W-1:0]  round_cnt_s1;

	// Stage 2: result register
	logic                          valid_s2;
	logic [pgra_pkg::OUT_W-1:0]    new_p_s2;
	logic [pgra_pkg::OUT_W-1:0]    new_i_s2;
	logic [pgra_pkg::OUT_W-1:0]    new_d_s2;
	pgra_pkg::rule_t               rule_s2;

	logic [GAIN_WIDTH-1:0]         lim_p;
	logic [GAIN_WIDTH-1:0]         lim_i;
	logic [GAIN_WIDTH-1:0]         lim_d;

	logic                          adv;       // s1 moves into s2 this cycle
	logic                          load_s1;   // input transaction accepted

	pgra_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Flow control: s2 frees up when empty or being taken downstream
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= load_s1 || (valid_s1 && !adv);
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cur_p_s1        <= cur_p;
			cur_i_s1        <= cur_i;
			cur_d_s1        <= cur_d;
			err_mean_s1     <= err_mean;
			error_spread_s1 <= error_spread;
			round_cnt_s1    <= round_cnt;
		end
	end

	// Rule choice on the registered item
	pgra_rule_sel u_rule (
		.cons_enable  (cfg.cons_enable),
		.gain_factor  (cfg.gain_factor),
		.err_mean     (err_mean_s1),
		.error_spread (error_spread_s1),
		.round_cnt    (round_cnt_s1),
		.ctl          (ctl)
	);

	// One lane per gain: scale, rate limit against current gain, clamp
	pgra_gain_limit #(.GW(GAIN_WIDTH)) u_lim_p (
		.cur     (cur_p_s1),
		.k       (ctl.kp),
		.ratio   (cfg.p_rate_lim),
		.ceiling (cfg.p_ceiling),
		.res     (lim_p)
	);

	pgra_gain_limit #(.GW(GAIN_WIDTH)) u_lim_i (
		.cur     (cur_i_s1),
		.k       (ctl.ki),
		.ratio   (cfg.i_rate_lim),
		.ceiling (cfg.i_ceiling),
		.res     (lim_i)
	);

	pgra_gain_limit #(.GW(GAIN_WIDTH)) u_lim_d (
		.cur     (cur_d_s1),
		.k       (ctl.kd),
		.ratio   (cfg.d_rate_lim),
		.ceiling (cfg.d_ceiling),
		.res     (lim_d)
	);

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			new_p_s2 <= pgra_pkg::OUT_W'(lim_p);
			new_i_s2 <= pgra_pkg::OUT_W'(lim_i);
			new_d_s2 <= pgra_pkg::OUT_W'(lim_d);
			rule_s2  <= ctl.rule;
		end
	end

	assign out_valid  = valid_s2;
	assign new_p      = new_p_s2;
	assign new_i      = new_i_s2;
	assign new_d      = new_d_s2;
	assign rule_taken = rule_s2;

	// Back-pressure only when the input register is occupied
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with empty input register");

	// A held item in s1 stays until it can advance
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("stalled item dropped from input register");

	// Results never exceed their ceilings
	a_p_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (new_p_s2 <= cfg.p_ceiling))
		else $error("new_p above p_ceiling");

	a_i_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (new_i_s2 <= cfg.i_ceiling))
		else $error("new_i above i_ceiling");

	a_d_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (new_d_s2 <= cfg.d_ceiling))
		else $error("new_d above d_ceiling");

endmodule
